// File: rtl/m3i_pkg.sv
// Shared definitions for the 3x3 matrix inverse pipeline.
// No dependencies; every other file in rtl/ but the two interfaces refers to it by scoped names.
package m3i_pkg;

  // Entries in one 3x3 matrix, and its side length.
  localparam int N_ENT = 9;
  localparam int N_DIM = 3;

  // Control that travels beside the data from one pipeline section to the next.
  typedef struct packed {
    logic vld;
    logic sing;
  } tag_t;

endpackage

// File: rtl/m3i_in_if.sv
// Input channel of the matrix inverse: valid/ready plus nine signed entries.
// Depends on nothing.
interface m3i_in_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] in_r0c0, in_r0c1, in_r0c2;
  logic signed [W-1:0] in_r1c0, in_r1c1, in_r1c2;
  logic signed [W-1:0] in_r2c0, in_r2c1, in_r2c2;

  modport source (output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                  in_r2c0, in_r2c1, in_r2c2, input ready);
  modport sink   (input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                  in_r2c0, in_r2c1, in_r2c2, output ready);
endinterface

// File: rtl/m3i_out_if.sv
// Output channel of the matrix inverse: valid/ready, nine entries and a flag.
// Depends on nothing.
interface m3i_out_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] out_r0c0, out_r0c1, out_r0c2;
  logic signed [W-1:0] out_r1c0, out_r1c1, out_r1c2;
  logic signed [W-1:0] out_r2c0, out_r2c1, out_r2c2;
  logic                singular;

  modport source (output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
                  out_r2c0, out_r2c1, out_r2c2, singular, input ready);
  modport sink   (input valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
                  out_r2c0, out_r2c1, out_r2c2, singular, output ready);
endinterface

// File: rtl/mat3_inverse.sv
// Top level of the 3x3 matrix inverse: adjugate section, divider section and
// output section. Uses m3i_pkg, m3i_in_if, m3i_out_if, m3i_adj, m3i_div, m3i_sat.
//
//   channel  role    content
//   in_i     sink    nine signed entries of the matrix, row-major
//   out_o    source  nine signed entries of the inverse and the singular flag
//
// Pipeline: seven adjugate stages, one overflow check and one stage per quotient
// bit, one saturation stage and the output register. One item enters per cycle
// while the skid register is empty; the quotient bit stages set the depth. Reset
// clears only the valid bits and the divider's singular tags. When the output is
// stalled, one more item lands in a skid register, then the whole pipeline holds.
module mat3_inverse #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  m3i_in_if.sink    in_i,
  m3i_out_if.source out_o
);

  localparam int RW = (2 * WORD_BITS + 2 * FRAC_BITS + 4 > 4 * WORD_BITS + 5) ?
                      2 * WORD_BITS + 2 * FRAC_BITS + 4 : 4 * WORD_BITS + 5;

  logic                        adv;
  logic signed [WORD_BITS-1:0] mat [m3i_pkg::N_ENT];
  m3i_pkg::tag_t               adj_tag, div_tag;
  logic [RW-1:0]               num [m3i_pkg::N_ENT];
  logic [RW-1:0]               dd;
  logic                        adj_neg [m3i_pkg::N_ENT];
  logic [WORD_BITS-1:0]        quo [m3i_pkg::N_ENT];
  logic                        big [m3i_pkg::N_ENT];
  logic                        div_neg [m3i_pkg::N_ENT];

  assign mat[0] = in_i.in_r0c0;
  assign mat[1] = in_i.in_r0c1;
  assign mat[2] = in_i.in_r0c2;
  assign mat[3] = in_i.in_r1c0;
  assign mat[4] = in_i.in_r1c1;
  assign mat[5] = in_i.in_r1c2;
  assign mat[6] = in_i.in_r2c0;
  assign mat[7] = in_i.in_r2c1;
  assign mat[8] = in_i.in_r2c2;

  assign in_i.ready = adv;

  m3i_adj #(.W(WORD_BITS), .F(FRAC_BITS), .RW(RW)) u_adj (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (in_i.valid),
    .mat_i  (mat),
    .tag_o  (adj_tag),
    .num_o  (num),
    .dd_o   (dd),
    .neg_o  (adj_neg)
  );

  m3i_div #(.W(WORD_BITS), .RW(RW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .tag_i  (adj_tag),
    .num_i  (num),
    .dd_i   (dd),
    .neg_i  (adj_neg),
    .tag_o  (div_tag),
    .q_o    (quo),
    .big_o  (big),
    .neg_o  (div_neg)
  );

  m3i_sat #(.W(WORD_BITS)) u_sat (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (div_tag),
    .q_i    (quo),
    .big_i  (big),
    .neg_i  (div_neg),
    .adv_o  (adv),
    .out_o  (out_o)
  );

endmodule

// File: rtl/m3i_adj.sv
// Adjugate and determinant section: seven register stages that form the cross
// products, the determinant, and the numerator and divisor for each entry. Uses m3i_pkg.
module m3i_adj #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int RW = 133
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                vld_i,
  input  logic signed [W-1:0] mat_i [m3i_pkg::N_ENT],
  output m3i_pkg::tag_t       tag_o,
  output logic [RW-1:0]       num_o [m3i_pkg::N_ENT],
  output logic [RW-1:0]       dd_o,
  output logic                neg_o [m3i_pkg::N_ENT]
);

  localparam int PW = 2 * W;
  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 3;

  logic [6:0] v_q;

  // Stage 1: products of the cross terms.
  logic signed [PW-1:0] pa_q [m3i_pkg::N_ENT];
  logic signed [PW-1:0] pb_q [m3i_pkg::N_ENT];
  logic signed [W-1:0]  c1_q [m3i_pkg::N_DIM];
  // Stage 2: cross products.
  logic signed [CW-1:0] cr2_q [m3i_pkg::N_ENT];
  logic signed [W-1:0]  c2_q  [m3i_pkg::N_DIM];
  // Stage 3: determinant partial products, split at bit W of the cross entry.
  logic signed [CW-1:0] plo_q [m3i_pkg::N_DIM];
  logic signed [CW-1:0] phi_q [m3i_pkg::N_DIM];
  logic signed [CW-1:0] cr3_q [m3i_pkg::N_ENT];
  // Stage 4: one term of the dot product per column.
  logic signed [DW-1:0] t_q   [m3i_pkg::N_DIM];
  logic signed [CW-1:0] cr4_q [m3i_pkg::N_ENT];
  // Stage 5: determinant.
  logic signed [DW-1:0] det_q;
  logic signed [CW-1:0] cr5_q [m3i_pkg::N_ENT];
  // Stage 6: magnitudes and result signs.
  logic [CW-1:0]        ac_q  [m3i_pkg::N_ENT];
  logic [DW-1:0]        ad_q;
  logic                 neg6_q [m3i_pkg::N_ENT];
  logic                 zero6_q;
  // Stage 7: numerator with the rounding half added, and twice the divisor.
  logic [RW-1:0]        num_q [m3i_pkg::N_ENT];
  logic [RW-1:0]        dd_q;
  logic                 neg7_q [m3i_pkg::N_ENT];
  logic                 zero7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[5:0], vld_i};
    end
  end

  for (genvar e = 0; e < m3i_pkg::N_ENT; e++) begin : g_ent
    // Row r of the inverse is the cross product of columns r+1 and r+2.
    localparam int R  = e / 3;
    localparam int K  = e % 3;
    localparam int U  = (R + 1) % 3;
    localparam int V  = (R + 2) % 3;
    localparam int I1 = (K + 1) % 3;
    localparam int I2 = (K + 2) % 3;

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        pa_q[e]   <= mat_i[I1*3+U] * mat_i[I2*3+V];
        pb_q[e]   <= mat_i[I2*3+U] * mat_i[I1*3+V];
        cr2_q[e]  <= CW'(pa_q[e]) - CW'(pb_q[e]);
        cr3_q[e]  <= cr2_q[e];
        cr4_q[e]  <= cr3_q[e];
        cr5_q[e]  <= cr4_q[e];
        ac_q[e]   <= cr5_q[e][CW-1] ? CW'(-cr5_q[e]) : CW'(cr5_q[e]);
        neg6_q[e] <= cr5_q[e][CW-1] ^ det_q[DW-1];
        num_q[e]  <= (RW'(ac_q[e]) << (2 * F + 1)) + RW'(ad_q);
        neg7_q[e] <= neg6_q[e];
      end
    end
  end

  for (genvar k = 0; k < m3i_pkg::N_DIM; k++) begin : g_dot
    logic signed [W:0] lo;
    logic signed [W:0] hi;
    logic signed [DW-1:0] hi_ext;
    assign lo     = $signed({1'b0, cr2_q[6+k][W-1:0]});
    assign hi     = cr2_q[6+k][CW-1:W];
    assign hi_ext = DW'(phi_q[k]);

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        c1_q[k]  <= mat_i[k*3+2];
        c2_q[k]  <= c1_q[k];
        plo_q[k] <= lo * c2_q[k];
        phi_q[k] <= hi * c2_q[k];
        t_q[k]   <= (hi_ext <<< W) + DW'(plo_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      det_q   <= t_q[0] + t_q[1] + t_q[2];
      ad_q    <= det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
      zero6_q <= (det_q == '0);
      dd_q    <= RW'(ad_q) << 1;
      zero7_q <= zero6_q;
    end
  end

  assign tag_o.vld  = v_q[6];
  assign tag_o.sing = zero7_q;
  assign num_o      = num_q;
  assign dd_o       = dd_q;
  assign neg_o      = neg7_q;

endmodule

// File: rtl/m3i_div.sv
// Restoring divider section: one overflow check stage, then one stage per
// quotient bit, nine lanes sharing one divisor. Uses m3i_pkg.
module m3i_div #(
  parameter int W  = 32,
  parameter int RW = 133
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  m3i_pkg::tag_t   tag_i,
  input  logic [RW-1:0]   num_i [m3i_pkg::N_ENT],
  input  logic [RW-1:0]   dd_i,
  input  logic            neg_i [m3i_pkg::N_ENT],
  output m3i_pkg::tag_t   tag_o,
  output logic [W-1:0]    q_o   [m3i_pkg::N_ENT],
  output logic            big_o [m3i_pkg::N_ENT],
  output logic            neg_o [m3i_pkg::N_ENT]
);

  logic [RW-1:0] rem_q [W+1][m3i_pkg::N_ENT];
  logic [W-1:0]  quo_q [W+1][m3i_pkg::N_ENT];
  logic          big_q [W+1][m3i_pkg::N_ENT];
  logic          neg_q [W+1][m3i_pkg::N_ENT];
  logic [RW-1:0] dd_q  [W+1];
  m3i_pkg::tag_t tag_q [W+1];

  // A quotient of 2^W or more saturates whatever its low bits are.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[0] <= '0;
    end else if (adv_i) begin
      tag_q[0] <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dd_q[0] <= dd_i;
    end
  end

  for (genvar l = 0; l < m3i_pkg::N_ENT; l++) begin : g_chk
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[0][l] <= num_i[l];
        quo_q[0][l] <= '0;
        big_q[0][l] <= (num_i[l] >= (dd_i << W));
        neg_q[0][l] <= neg_i[l];
      end
    end
  end

  for (genvar s = 1; s <= W; s++) begin : g_step
    localparam int B = W - s;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[s] <= '0;
      end else if (adv_i) begin
        tag_q[s] <= tag_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        dd_q[s] <= dd_q[s-1];
      end
    end

    for (genvar l = 0; l < m3i_pkg::N_ENT; l++) begin : g_lane
      logic [RW:0] trial;
      logic        take;
      assign trial = {1'b0, rem_q[s-1][l]} - {1'b0, dd_q[s-1] << B};
      assign take  = !trial[RW];

      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          rem_q[s][l] <= take ? trial[RW-1:0] : rem_q[s-1][l];
          quo_q[s][l] <= quo_q[s-1][l] | ({{(W-1){1'b0}}, take} << B);
          big_q[s][l] <= big_q[s-1][l];
          neg_q[s][l] <= neg_q[s-1][l];
        end
      end
    end
  end

  assign tag_o = tag_q[W];
  assign q_o   = quo_q[W];
  assign big_o = big_q[W];
  assign neg_o = neg_q[W];

endmodule

// File: rtl/m3i_sat.sv
// Saturation, sign and singular handling, then an output register with a skid
// register that produces the pipeline advance. Uses m3i_pkg and m3i_out_if.
module m3i_sat #(
  parameter int W = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  m3i_pkg::tag_t tag_i,
  input  logic [W-1:0]  q_i   [m3i_pkg::N_ENT],
  input  logic          big_i [m3i_pkg::N_ENT],
  input  logic          neg_i [m3i_pkg::N_ENT],
  output logic          adv_o,
  m3i_out_if.source     out_o
);

  localparam logic [W-1:0] POS_LIM = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NEG_LIM = {1'b1, {(W-1){1'b0}}};

  logic         adv;
  logic         fin_v_q;
  logic         fin_sing_q;
  logic [W-1:0] fin_q  [m3i_pkg::N_ENT];
  logic         out_v_q, skid_v_q;
  logic         out_sing_q, skid_sing_q;
  logic [W-1:0] out_q  [m3i_pkg::N_ENT];
  logic [W-1:0] skid_q [m3i_pkg::N_ENT];
  logic         take, arrive, load_out;

  assign adv = !skid_v_q;

  for (genvar l = 0; l < m3i_pkg::N_ENT; l++) begin : g_fin
    logic [W-1:0] lim, mag;
    assign lim = neg_i[l] ? NEG_LIM : POS_LIM;
    assign mag = (big_i[l] || (q_i[l] > lim)) ? lim : q_i[l];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        fin_q[l] <= tag_i.sing ? '0 : (neg_i[l] ? W'(-mag) : mag);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q <= 1'b0;
    end else if (adv) begin
      fin_v_q <= tag_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fin_sing_q <= tag_i.sing;
    end
  end

  // While the skid register holds an item every stage before the output register is frozen.
  assign take     = out_v_q && out_o.ready;
  assign arrive   = adv && fin_v_q;
  assign load_out = !out_v_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (load_out) begin
      out_v_q  <= skid_v_q || arrive;
      skid_v_q <= skid_v_q && arrive;
    end else begin
      skid_v_q <= skid_v_q || arrive;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q      <= skid_v_q ? skid_q : fin_q;
      out_sing_q <= skid_v_q ? skid_sing_q : fin_sing_q;
    end
    if (arrive && (!load_out || skid_v_q)) begin
      skid_q      <= fin_q;
      skid_sing_q <= fin_sing_q;
    end
  end

  assign adv_o          = adv;
  assign out_o.valid    = out_v_q;
  assign out_o.singular = out_sing_q;
  assign out_o.out_r0c0 = out_q[0];
  assign out_o.out_r0c1 = out_q[1];
  assign out_o.out_r0c2 = out_q[2];
  assign out_o.out_r1c0 = out_q[3];
  assign out_o.out_r1c1 = out_q[4];
  assign out_o.out_r1c2 = out_q[5];
  assign out_o.out_r2c0 = out_q[6];
  assign out_o.out_r2c1 = out_q[7];
  assign out_o.out_r2c2 = out_q[8];

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds an item while the output register is empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !$past(skid_v_q)) |-> $past(out_v_q && !out_o.ready))
    else $error("skid register filled although the output item was taken");

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_sing_q) |-> (out_q[0] == '0 && out_q[4] == '0 && out_q[8] == '0))
    else $error("singular item carries nonzero entries");

  a_no_advance_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(skid_v_q) |-> $stable(fin_v_q))
    else $error("final stage moved while the pipeline was frozen");

endmodule

// File: sim/tb_mat3_inverse.sv
// Self-checking testbench for mat3_inverse: drives 3x3 Q16.16 matrices and checks
// every returned inverse against an exact wide-integer adjugate computation.
// Depends on rtl/m3i_pkg.sv, rtl/m3i_in_if.sv, rtl/m3i_out_if.sv and the RTL.
`timescale 1ns / 100ps

module tb_mat3_inverse;

  localparam int FRAC = 16;
  localparam int WB   = 32;
  localparam logic [WB-1:0] ONE    = 32'h0001_0000;
  localparam logic [WB-1:0] MAXW   = 32'h7fff_ffff;
  localparam logic [WB-1:0] MINW   = 32'h8000_0000;
  localparam int   LIMIT_CYCLES    = 400000;
  localparam int   TAIL_CYCLES     = 60;
  localparam int   N_DIRECTED      = 12;
  localparam int   N_PER_PHASE     = 125;

  typedef logic [m3i_pkg::N_ENT-1:0][WB-1:0] mat_t;
  typedef struct packed {
    logic sing;
    mat_t ent;
  } inv_t;
  typedef logic signed [191:0] wide_t;
  typedef wide_t vec_t [3];
  typedef struct {
    mat_t m;
    bit   known;
    inv_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  int   n_errors = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  inv_t pending_inv[$];
  row_t directed[N_DIRECTED];

  m3i_in_if  #(.W(WB)) in_ch ();
  m3i_out_if #(.W(WB)) out_ch ();

  mat3_inverse #(.FRAC_BITS(FRAC), .WORD_BITS(WB)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb_mat3_inverse NOT OK");
      $finish;
    end
  end

  function automatic vec_t cross3(vec_t u, vec_t v);
    vec_t r;
    r[0] = u[1] * v[2] - u[2] * v[1];
    r[1] = u[2] * v[0] - u[0] * v[2];
    r[2] = u[0] * v[1] - u[1] * v[0];
    return r;
  endfunction

  // Rounded (ties away from zero) and saturated c * 2^(2F) / d.
  function automatic logic [WB-1:0] quotient(wide_t c, wide_t d);
    logic  neg;
    wide_t ac, ad, q, lim;
    neg = (c < 0) != (d < 0);
    ac = (c < 0) ? -c : c;
    ad = (d < 0) ? -d : d;
    q = ((ac <<< (2 * FRAC + 1)) + ad) / (ad <<< 1);
    lim = neg ? (wide_t'(1) <<< (WB - 1)) : ((wide_t'(1) <<< (WB - 1)) - 1);
    if (q > lim) q = lim;
    if (neg) q = -q;
    return q[WB-1:0];
  endfunction

  function automatic inv_t invert(mat_t m);
    vec_t  col[3];
    vec_t  adj[3];
    wide_t det;
    inv_t  r;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        col[k][i] = wide_t'(signed'(m[i * 3 + k]));
    adj[0] = cross3(col[1], col[2]);
    adj[1] = cross3(col[2], col[0]);
    adj[2] = cross3(col[0], col[1]);
    det = adj[2][0] * col[2][0] + adj[2][1] * col[2][1] + adj[2][2] * col[2][2];
    r = '0;
    if (det == 0) begin
      r.sing = 1'b1;
    end else begin
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++)
          r.ent[i * 3 + k] = quotient(adj[i][k], det);
    end
    return r;
  endfunction

  function automatic mat_t diag(logic [WB-1:0] x);
    mat_t m;
    m = '0;
    m[0] = x;
    m[4] = x;
    m[8] = x;
    return m;
  endfunction

  function automatic mat_t rand_mat(int mode);
    mat_t m;
    for (int i = 0; i < m3i_pkg::N_ENT; i++) begin
      case (mode)
        0: m[i] = $urandom;
        1: m[i] = WB'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        default: m[i] = WB'($signed($urandom_range(0, 32'h0000_0400)) - 32'sh0000_0200);
      endcase
    end
    return m;
  endfunction

  task automatic send(mat_t m);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    {in_ch.in_r2c2, in_ch.in_r2c1, in_ch.in_r2c0, in_ch.in_r1c2, in_ch.in_r1c1,
     in_ch.in_r1c0, in_ch.in_r0c2, in_ch.in_r0c1, in_ch.in_r0c0} = m;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_inv.push_back(invert(m));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending_inv.size() != 0) @(negedge clk_i);
  endtask

  // Receiver side: random stall chosen at each falling edge.
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    inv_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.sing = out_ch.singular;
      got.ent = {out_ch.out_r2c2, out_ch.out_r2c1, out_ch.out_r2c0, out_ch.out_r1c2,
                 out_ch.out_r1c1, out_ch.out_r1c0, out_ch.out_r0c2, out_ch.out_r0c1,
                 out_ch.out_r0c0};
      if (pending_inv.size() == 0) begin
        $error("unexpected result item");
        n_errors++;
      end else begin
        want = pending_inv.pop_front();
        if (got.sing !== want.sing) begin
          $error("singular: expected %0d, got %0d", want.sing, got.sing);
          n_errors++;
        end
        for (int i = 0; i < m3i_pkg::N_ENT; i++) begin
          if (got.ent[i] !== want.ent[i]) begin
            $error("out_r%0dc%0d: expected %h, got %h", i / 3, i % 3, want.ent[i],
                   got.ent[i]);
            n_errors++;
          end
        end
      end
    end
  end

  initial begin
    mat_t m;
    inv_t r;
    in_ch.valid = 1'b0;
    {in_ch.in_r2c2, in_ch.in_r2c1, in_ch.in_r2c0, in_ch.in_r1c2, in_ch.in_r1c1,
     in_ch.in_r1c0, in_ch.in_r0c2, in_ch.in_r0c1, in_ch.in_r0c0} = '0;
    out_ch.ready = 1'b0;

    // Directed rows; a result is typed in only where it is obvious.
    r = '0;
    r.ent = diag(ONE);
    directed[0] = '{diag(ONE), 1'b1, r};
    r = '0;
    r.sing = 1'b1;
    directed[1] = '{'0, 1'b1, r};
    directed[2] = '{{m3i_pkg::N_ENT{MINW}}, 1'b1, r};
    directed[3] = '{{m3i_pkg::N_ENT{MAXW}}, 1'b1, r};
    m = rand_mat(0);
    m[6] = m[0];
    m[7] = m[1];
    m[8] = m[2];
    directed[4] = '{m, 1'b1, r};
    r = '0;
    r.ent = diag(32'h0000_8000);
    directed[5] = '{diag(32'h0002_0000), 1'b1, r};
    r.ent = diag(MAXW);
    directed[6] = '{diag(32'h0000_0001), 1'b1, r};
    r.ent = diag(MINW);
    directed[7] = '{diag(32'hffff_ffff), 1'b1, r};
    directed[8] = '{diag(MAXW), 1'b0, r};
    directed[9] = '{diag(MINW), 1'b0, r};
    m = '0;
    m[1] = ONE;
    m[5] = 32'hfffe_0000;
    m[6] = 32'h0003_0000;
    directed[10] = '{m, 1'b0, r};
    directed[11] = '{diag(32'h0003_0000), 1'b0, r};

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].known && invert(directed[i].m) !== directed[i].res) begin
        $error("row %0d: typed result disagrees with the predictor", i);
        n_errors++;
      end
      send(directed[i].m);
    end
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 85 : 9) : 0;
      stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 85 : 9) : 0;
      for (int n = 0; n < N_PER_PHASE; n++) begin
        m = rand_mat($urandom_range(0, 2));
        // Some matrices get a copied column, which makes them singular.
        if ($urandom_range(0, 9) == 0) begin
          m[2] = m[0];
          m[5] = m[3];
          m[8] = m[6];
        end
        send(m);
      end
      // The sender holds off here until all results are back.
      drain();
    end

    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_errors == 0 && pending_inv.size() == 0) begin
      $display("tb_mat3_inverse OK");
    end else begin
      $display("tb_mat3_inverse NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/m3i_pkg.sv
rtl/m3i_in_if.sv
rtl/m3i_out_if.sv
rtl/m3i_adj.sv
rtl/m3i_div.sv
rtl/m3i_sat.sv
rtl/mat3_inverse.sv
sim/tb_mat3_inverse.sv
